// File: rtl/tcce_pkg.sv
// Shared types, constants and helpers for the text console cursor engine.
`timescale 1ns / 1ps

package tcce_pkg;

  // Glyph cell geometry and tab stop spacing
  localparam int GLYPH_WIDTH  = 8;
  localparam int GLYPH_HEIGHT = 16;
  localparam int TAB_CELLS    = 4;

  // Configuration register indexes and reset values
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = CFG_IDX_W'(1);
  localparam int SCREEN_WIDTH_RST  = 640;
  localparam int SCREEN_HEIGHT_RST = 480;
  localparam int SCR_W = 13;

  // Operation, result kind and character codes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_MOVE = 1'b1;
  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7e;

  // Spaces left in one tab run: 1 .. TAB_CELLS
  localparam int CNT_W = $clog2(TAB_CELLS + 1);
  typedef logic [CNT_W-1:0] cnt_t;

  // Signed wrap / scroll limit: screen size minus glyph size
  localparam int LIM_W = SCR_W + 1;
  typedef logic signed [LIM_W-1:0] lim_t;
  localparam lim_t WLIM_RST = lim_t'(SCREEN_WIDTH_RST - GLYPH_WIDTH);
  localparam lim_t HLIM_RST = lim_t'(SCREEN_HEIGHT_RST - GLYPH_HEIGHT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADV,
    ST_NEWL,
    ST_FLUSH
  } seq_state_t;

  typedef struct packed {
    logic [SCR_W-1:0] screen_width;
    logic [SCR_W-1:0] screen_height;
    lim_t             wlim;
    lim_t             hlim;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  glyph_code;
    logic [31:0] glyph_color;
  } res_t;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] k;
    lim_t        lim;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] sum;
    logic        ge;
  } alu_rsp_t;

  function automatic logic is_printable(input logic [7:0] code);
    return (code >= CH_SPACE) && (code <= CH_TILDE);
  endfunction

endpackage

// File: rtl/tcce_ifs.sv
// Valid/ready channel interfaces: input items, result items and register writes.
`timescale 1ns / 1ps

interface tcce_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  char_code;
  logic [31:0] color;
  logic [15:0] new_x;
  logic [15:0] new_y;

  modport source (output valid, operation, char_code, color, new_x, new_y, input ready);
  modport sink   (input valid, operation, char_code, color, new_x, new_y, output ready);
endinterface

interface tcce_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [7:0]  glyph_code;
  logic [31:0] glyph_color;
  logic        last;

  modport source (output valid, kind, pos_x, pos_y, glyph_code, glyph_color, last,
                  input ready);
  modport sink   (input valid, kind, pos_x, pos_y, glyph_code, glyph_color, last,
                  output ready);
endinterface

interface tcce_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/text_console_cursor_engine_unit.sv
// Top level of the text console cursor engine: screen registers and sequencer.
`timescale 1ns / 1ps

//  channel  dir  handshake        item contents
//  -------  ---  ---------------  ---------------------------------------------
//  in_ch    in   valid / ready    operation, char_code, color, new_x, new_y
//  out_ch   out  valid / ready    kind, pos_x, pos_y, glyph_code, glyph_color, last
//  cfg_ch   in   valid / ready    index (0 width, 1 height), data
//
//  An item is taken and then, while out_ch does not stall, worked on one step a
//  cycle: a glyph step (draw, advance, wrap test) or a row step (new line,
//  scroll test), both on the one shared add-and-compare unit. Characters and
//  tabs run glyph steps (a row step on a wrap), a newline a row step, then a
//  flush step; a move or carriage return needs none. in_ch is not ready meanwhile.
//  Each result sits in a pending register until it is known whether another
//  follows, so last is exact. Any out_ch stall holds the sequencer.
//  rst_n (synchronous) clears the cursor to 0,0 and sets 640 x 480.

module text_console_cursor_engine_unit import tcce_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  tcce_in_if.sink    in_ch,
  tcce_out_if.source out_ch,
  tcce_cfg_if.sink   cfg_ch
);

  logic [SCR_W-1:0] sw_r;
  logic [SCR_W-1:0] sh_r;
  lim_t             wlim_r;
  lim_t             hlim_r;
  cfg_t             cfg;
  res_t             res;

  // register writes are always taken
  assign cfg_ch.ready = 1'b1;

  // Limits kept precomputed so each step needs only one add and compare.
  // Small screens give a negative limit, which always trips the test.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r   <= SCR_W'(SCREEN_WIDTH_RST);
      sh_r   <= SCR_W'(SCREEN_HEIGHT_RST);
      wlim_r <= WLIM_RST;
      hlim_r <= HLIM_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_SCREEN_WIDTH: begin
          sw_r   <= cfg_ch.data;
          wlim_r <= $signed({1'b0, cfg_ch.data}) - lim_t'(GLYPH_WIDTH);
        end
        CFG_SCREEN_HEIGHT: begin
          sh_r   <= cfg_ch.data;
          hlim_r <= $signed({1'b0, cfg_ch.data}) - lim_t'(GLYPH_HEIGHT);
        end
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  assign cfg.screen_width  = sw_r;
  assign cfg.screen_height = sh_r;
  assign cfg.wlim          = wlim_r;
  assign cfg.hlim          = hlim_r;

  tcce_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_operation (in_ch.operation),
    .in_char_code (in_ch.char_code),
    .in_color     (in_ch.color),
    .in_new_x     (in_ch.new_x),
    .in_new_y     (in_ch.new_y),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_res      (res),
    .out_last     (out_ch.last)
  );

  assign out_ch.kind        = res.kind;
  assign out_ch.pos_x       = res.pos_x;
  assign out_ch.pos_y       = res.pos_y;
  assign out_ch.glyph_code  = res.glyph_code;
  assign out_ch.glyph_color = res.glyph_color;

endmodule

// File: rtl/tcce_alu.sv
// Shared add-and-compare unit: cursor coordinate step plus signed limit test.
`timescale 1ns / 1ps

module tcce_alu import tcce_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [15:0]        sum;
  logic signed [17:0] sum_ext;
  logic signed [17:0] lim_ext;

  assign sum     = req.a + req.k;
  assign sum_ext = $signed({2'b00, sum});
  assign lim_ext = 18'(req.lim);

  assign rsp.sum = sum;
  assign rsp.ge  = (sum_ext >= lim_ext);

endmodule

// File: rtl/tcce_seq.sv
// Cursor sequencer: decodes items, steps the shared unit, holds pending and output results.
`timescale 1ns / 1ps

module tcce_seq import tcce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  // input item
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_char_code,
  input  logic [31:0] in_color,
  input  logic [15:0] in_new_x,
  input  logic [15:0] in_new_y,
  // result item
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_res,
  output logic        out_last
);

  seq_state_t  state_r, state_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;
  cnt_t        cnt_r, cnt_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [31:0] color_r, color_nxt;
  logic        pend_v_r, pend_v_nxt;
  res_t        pend_r, pend_nxt;
  logic        out_v_r, out_v_nxt;
  res_t        out_r, out_nxt;
  logic        out_last_r, out_last_nxt;

  logic        adv_ok;
  logic        emit;
  res_t        new_res;
  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;

  tcce_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_v_r;
  assign out_res   = out_r;
  assign out_last  = out_last_r;

  // a step may run only if the output slot is free after this edge
  assign adv_ok = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      col_r    <= '0;
      row_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    code_r     <= code_nxt;
    color_r    <= color_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    cnt_nxt      = cnt_r;
    code_nxt     = code_r;
    color_nxt    = color_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    out_v_nxt    = out_v_r && !out_ready;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    emit         = 1'b0;
    new_res      = '0;
    alu_req.a    = col_r;
    alu_req.k    = 16'(GLYPH_WIDTH);
    alu_req.lim  = cfg.wlim;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_operation == OP_MOVE) begin
            if (in_new_x < {3'b000, cfg.screen_width}) begin
              col_nxt = in_new_x;
            end
            if (in_new_y < {3'b000, cfg.screen_height}) begin
              row_nxt = in_new_y;
            end
          end else begin
            color_nxt = in_color;
            code_nxt  = in_char_code;
            case (in_char_code)
              CH_LF: begin
                cnt_nxt   = '0;
                state_nxt = ST_NEWL;
              end
              CH_CR: begin
                col_nxt = '0;
              end
              CH_TAB: begin
                code_nxt  = CH_SPACE;
                cnt_nxt   = CNT_W'(TAB_CELLS) - CNT_W'((col_r / GLYPH_WIDTH) % TAB_CELLS);
                state_nxt = ST_ADV;
              end
              default: begin
                cnt_nxt   = CNT_W'(1);
                state_nxt = ST_ADV;
              end
            endcase
          end
        end
      end

      ST_ADV: begin
        // draw at the cursor if printable, step the column, test against the wrap limit
        if (adv_ok) begin
          if (is_printable(code_r)) begin
            emit                = 1'b1;
            new_res.kind        = KIND_DRAW;
            new_res.pos_x       = col_r;
            new_res.pos_y       = row_r;
            new_res.glyph_code  = code_r;
            new_res.glyph_color = color_r;
          end
          cnt_nxt = cnt_r - CNT_W'(1);
          if (alu_rsp.ge) begin
            col_nxt   = '0;
            state_nxt = ST_NEWL;
          end else begin
            col_nxt   = alu_rsp.sum;
            state_nxt = (cnt_r == CNT_W'(1)) ? ST_FLUSH : ST_ADV;
          end
        end
      end

      ST_NEWL: begin
        // next row; on reaching the bottom limit scroll and keep the row
        alu_req.a   = row_r;
        alu_req.k   = 16'(GLYPH_HEIGHT);
        alu_req.lim = cfg.hlim;
        if (adv_ok) begin
          col_nxt = '0;
          if (alu_rsp.ge) begin
            emit         = 1'b1;
            new_res.kind = KIND_SCROLL;
          end else begin
            row_nxt = alu_rsp.sum;
          end
          state_nxt = (cnt_r != '0) ? ST_ADV : ST_FLUSH;
        end
      end

      ST_FLUSH: begin
        if (adv_ok) begin
          if (pend_v_r) begin
            out_nxt      = pend_r;
            out_last_nxt = 1'b1;
            out_v_nxt    = 1'b1;
            pend_v_nxt   = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // a new result pushes the pending one out, which cannot be the last
    if (emit) begin
      if (pend_v_r) begin
        out_nxt      = pend_r;
        out_last_nxt = 1'b0;
        out_v_nxt    = 1'b1;
      end
      pend_nxt   = new_res;
      pend_v_nxt = 1'b1;
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// Self-checking bench for the text console cursor engine: directed and random items.
`timescale 1ns / 1ps

module tb_top;
  import tcce_pkg::*;

  // One expected command on the result channel
  typedef struct packed {
    logic        kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  code;
    logic [31:0] colour;
    logic        last;
  } cmd_t;

  localparam int MAX_CMDS = 8;

  logic clk;
  logic rst_n;

  tcce_in_if  in_ch();
  tcce_out_if out_ch();
  tcce_cfg_if cfg_ch();

  text_console_cursor_engine_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predicted console state: cursor and screen size
  logic [15:0]      cur_col;
  logic [15:0]      cur_row;
  logic [SCR_W-1:0] scr_w;
  logic [SCR_W-1:0] scr_h;

  cmd_t due_cmds[$];   // commands still to come from the block, oldest first
  cmd_t burst[$];      // commands caused by the item being predicted
  int   mismatches;

  // Handshake pressure, as percentages per cycle
  int send_idle_pct;
  int sink_stall_pct;

  // 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Console predictor
  // ---------------------------------------------------------------------------

  // Commands beyond eight per item are dropped; the cursor still moves on.
  function automatic void emit_cmd(logic kind, logic [15:0] x, logic [15:0] y,
                                   logic [7:0] code, logic [31:0] colour);
    cmd_t c;
    if (burst.size() < MAX_CMDS) begin
      c = '{kind, x, y, code, colour, 1'b0};
      burst.push_back(c);
    end
  endfunction

  // Limits are signed: a tiny screen gives a negative limit, so the test holds.
  // Only one scroll per test, even if the row is still past the limit.
  function automatic void test_scroll();
    if (int'(cur_row) >= int'(scr_h) - GLYPH_HEIGHT) begin
      emit_cmd(KIND_SCROLL, '0, '0, '0, '0);
      cur_row = cur_row - 16'(GLYPH_HEIGHT);
    end
  endfunction

  function automatic void start_new_line();
    cur_col = '0;
    cur_row = cur_row + 16'(GLYPH_HEIGHT);
    test_scroll();
  endfunction

  // Draw if printable, then advance and wrap near the right edge
  function automatic void glyph_step(logic [7:0] code, logic [31:0] colour);
    if (code >= CH_SPACE && code <= CH_TILDE)
      emit_cmd(KIND_DRAW, cur_col, cur_row, code, colour);
    cur_col = cur_col + 16'(GLYPH_WIDTH);
    if (int'(cur_col) >= int'(scr_w) - GLYPH_WIDTH)
      start_new_line();
  endfunction

  function automatic void predict_console(logic op, logic [7:0] ch, logic [31:0] colour,
                                          logic [15:0] nx, logic [15:0] ny);
    int spaces;
    burst.delete();
    if (op == OP_MOVE) begin
      // each coordinate is taken only when it lies on the screen
      if (nx < scr_w) cur_col = nx;
      if (ny < scr_h) cur_row = ny;
    end else begin
      case (ch)
        CH_LF: start_new_line();
        CH_CR: cur_col = '0;
        CH_TAB: begin
          spaces = TAB_CELLS - ((int'(cur_col) / GLYPH_WIDTH) % TAB_CELLS);
          for (int i = 0; i < spaces; i++)
            glyph_step(CH_SPACE, colour);
        end
        default: glyph_step(ch, colour);
      endcase
    end
    if (burst.size() > 0)
      burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i])
      due_cmds.push_back(burst[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t ns: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    mismatches++;
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want)
      report_mismatch(what, want, got);
  endtask

  // Every accepted result is held against the oldest outstanding command
  always @(posedge clk) begin : result_check
    cmd_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (due_cmds.size() == 0) begin
        report_mismatch("result with nothing due (pos_x)", '0, out_ch.pos_x);
      end else begin
        want = due_cmds.pop_front();
        check_field("kind", want.kind, out_ch.kind);
        check_field("pos_x", want.x, out_ch.pos_x);
        check_field("pos_y", want.y, out_ch.pos_y);
        check_field("glyph_code", want.code, out_ch.glyph_code);
        check_field("glyph_color", want.colour, out_ch.glyph_color);
        check_field("last", want.last, out_ch.last);
      end
    end
  end

  // Result side back-pressure, changed on the falling edge
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Drivers: every task starts and ends just after a falling edge
  // ---------------------------------------------------------------------------

  task automatic send_item(logic op, logic [7:0] ch, logic [31:0] colour,
                           logic [15:0] nx, logic [15:0] ny);
    in_ch.valid     = 1'b1;
    in_ch.operation = op;
    in_ch.char_code = ch;
    in_ch.color     = colour;
    in_ch.new_x     = nx;
    in_ch.new_y     = ny;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_console(op, ch, colour, nx, ny);
    @(negedge clk);
    in_ch.valid = 1'b0;
    // random sender gaps so that they land on every step of the sequencer
    while ($urandom_range(99) < send_idle_pct)
      @(negedge clk);
  endtask

  task automatic put_char(logic [7:0] ch);
    send_item(OP_PUT, ch, $urandom(), 16'($urandom()), 16'($urandom()));
  endtask

  task automatic move_cursor(logic [15:0] nx, logic [15:0] ny);
    send_item(OP_MOVE, 8'($urandom()), $urandom(), nx, ny);
  endtask

  // Wait for every outstanding command, then let a silent item finish too
  task automatic drain_results();
    while (due_cmds.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
    @(negedge clk);
  endtask

  // Screen registers are only written while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SCR_W-1:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    if (idx == CFG_SCREEN_WIDTH)
      scr_w = val;
    else if (idx == CFG_SCREEN_HEIGHT)
      scr_h = val;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_screen(int w, int h);
    drain_results();
    write_reg(CFG_SCREEN_WIDTH, SCR_W'(w));
    write_reg(CFG_SCREEN_HEIGHT, SCR_W'(h));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Printable bounds, non-printable codes and colour extremes on the reset screen
  task automatic test_printable_range();
    send_item(OP_PUT, 8'h41, 32'h0000_0000, 16'h0000, 16'h0000);
    send_item(OP_PUT, CH_SPACE, 32'hffff_ffff, 16'hffff, 16'hffff);
    put_char(CH_TILDE);
    put_char(8'h1f);     // just below printable
    put_char(8'h7f);     // just above printable
    put_char(8'h00);
    put_char(8'hff);
  endtask

  // Newline, carriage return, and tabs from an aligned and an odd column
  task automatic test_control_codes();
    put_char(CH_LF);
    put_char(CH_CR);
    put_char(CH_TAB);        // four spaces from column 0
    move_cursor(16'd12, 16'd16);
    put_char(CH_TAB);        // column 12 sits in cell 1: three spaces
  endtask

  // Moves on and off the screen, one coordinate taken without the other
  task automatic test_cursor_moves();
    move_cursor(16'hffff, 16'hffff);   // both rejected
    move_cursor(16'd639, 16'd0);       // right-most column
    put_char(8'h2a);                   // draws, then wraps
    move_cursor(16'd640, 16'd479);     // x off screen, y taken
    put_char(CH_LF);                   // past the bottom: scroll
  endtask

  // Smallest screen: every glyph wraps, a tab gives the full eight commands
  task automatic test_small_screen();
    set_screen(16, 32);
    move_cursor(16'd0, 16'd16);
    put_char(CH_TAB);
    put_char(CH_LF);
    put_char(8'h5a);
  endtask

  // A 4096 x 4096 screen, then shrink it so the row sits far below the limit
  task automatic test_row_past_limit();
    set_screen(4096, 4096);
    move_cursor(16'd4088, 16'd4000);
    put_char(8'h61);               // wrap without scroll
    move_cursor(16'd0, 16'd4000);
    set_screen(4096, 32);
    put_char(CH_LF);               // one scroll, row stays past the limit
    put_char(8'h23);
  endtask

  // Moves aimed at the edges half the time, else anywhere on the screen or in the 16-bit range
  task automatic random_move();
    int w;
    int h;
    logic [15:0] nx;
    logic [15:0] ny;
    w = int'(scr_w);
    h = int'(scr_h);
    case ($urandom_range(3))
      0: begin
        nx = 16'($urandom());
        ny = 16'($urandom());
      end
      1: begin
        nx = 16'($urandom_range(w - 1));
        ny = 16'($urandom_range(h - 1));
      end
      2: begin
        nx = 16'(w - 1 - $urandom_range((w > 24) ? 24 : w - 1));
        ny = 16'(h - 1 - $urandom_range((h > 40) ? 40 : h - 1));
      end
      default: begin
        nx = ($urandom_range(1)) ? 16'(w) : 16'd0;
        ny = ($urandom_range(1)) ? 16'(h) : 16'd0;
      end
    endcase
    move_cursor(nx, ny);
  endtask

  // Mostly printable text with control codes, odd bytes and moves mixed in
  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 55)
      put_char(8'($urandom_range(32, 126)));
    else if (r < 63)
      put_char(CH_LF);
    else if (r < 68)
      put_char(CH_CR);
    else if (r < 78)
      put_char(CH_TAB);
    else if (r < 86)
      put_char(8'($urandom_range(255)));
    else
      random_move();
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          set_screen(SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST);
          send_idle_pct  = 0;
          sink_stall_pct = 0;
        end
        1: begin
          set_screen(16, 32);
          send_idle_pct  = 46;
          sink_stall_pct = 0;
        end
        2: begin
          set_screen(4096, 4096);
          send_idle_pct  = 0;
          sink_stall_pct = 46;
        end
        default: begin
          set_screen($urandom_range(16, 4096), $urandom_range(32, 4096));
          send_idle_pct  = 11;
          sink_stall_pct = 11;
        end
      endcase
      for (int n = 0; n < 21; n++) begin
        // hold the next item back until the block has emptied its queue
        if (ph == 2 && n == 10) begin
          while (due_cmds.size() != 0)
            @(posedge clk);
          @(negedge clk);
        end
        random_item();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_PUT;
    in_ch.char_code = '0;
    in_ch.color     = '0;
    in_ch.new_x     = '0;
    in_ch.new_y     = '0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_SCREEN_WIDTH;
    cfg_ch.data     = '0;
    send_idle_pct   = 0;
    sink_stall_pct  = 0;
    mismatches      = 0;
    cur_col         = '0;
    cur_row         = '0;
    scr_w           = SCR_W'(SCREEN_WIDTH_RST);
    scr_h           = SCR_W'(SCREEN_HEIGHT_RST);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_printable_range();
    test_control_codes();
    test_cursor_moves();
    test_small_screen();
    test_row_past_limit();
    test_random_traffic();

    while (due_cmds.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// File: text_console_cursor_engine_unit.f
rtl/tcce_pkg.sv
rtl/tcce_ifs.sv
rtl/tcce_alu.sv
rtl/tcce_seq.sv
rtl/text_console_cursor_engine_unit.sv
tb/sv/tb_top.sv
